### design/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants of the chunked body decoder
// Payload structs, decoder state, limit registers, phase and status codes
// and the byte classifiers used by the step logic.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // decode phases
  localparam logic [2:0] PH_SIZE  = 3'd0;
  localparam logic [2:0] PH_DATA  = 3'd1;
  localparam logic [2:0] PH_CRLF  = 3'd2;
  localparam logic [2:0] PH_TRAIL = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_FAIL  = 3'd5;

  // result status codes
  localparam logic [2:0] ST_MORE     = 3'd0;
  localparam logic [2:0] ST_DATA     = 3'd1;
  localparam logic [2:0] ST_COMPLETE = 3'd2;
  localparam logic [2:0] ST_BAD      = 3'd3;
  localparam logic [2:0] ST_LARGE    = 3'd4;

  // limit register indexes
  localparam logic [1:0] REG_MAX_BODY   = 2'd0;
  localparam logic [1:0] REG_MAX_TRL_B  = 2'd1;
  localparam logic [1:0] REG_MAX_TRL_F  = 2'd2;

  // limit register reset values
  localparam logic [47:0] MAX_BODY_RST  = 48'd16777216;
  localparam logic [15:0] MAX_TRL_B_RST = 16'd8192;
  localparam logic [7:0]  MAX_TRL_F_RST = 8'd32;

  // special characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic        body_valid;
    logic        chunk_end;
    logic        consumed;
    logic [2:0]  status;
    logic [2:0]  phase;
    logic [47:0] body_count;
  } out_item_t;

  typedef struct packed {
    logic [47:0] max_body_bytes;
    logic [15:0] max_trailer_bytes;
    logic [7:0]  max_trailer_fields;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        error_kind;
    logic        cr_pending;
    logic [63:0] size_rem;
    logic        has_digit;
    logic        in_ext;
    logic        line_invalid;
    logic        colon_seen;
    logic [47:0] payload_total;
    logic [15:0] trl_bytes;
    logic [7:0]  trl_fields;
  } dec_state_t;

  // token character of a field name
  function automatic logic is_token(input logic [7:0] b);
    logic r;
    r = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h5a)) ||
        ((b >= 8'h61) && (b <= 8'h7a));
    case (b)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
      8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  // hex digit: bit 4 flags a valid digit, bits 3:0 give its value
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      r = {1'b1, b[3:0]};
    end else if (((b >= 8'h41) && (b <= 8'h46)) || ((b >= 8'h61) && (b <= 8'h66))) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### design/hcbd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_step: one-byte decode step
// Combinational next state and result for one input byte, given the
// current decoder state and the limit registers.
// ----------------------------------------------------------------------------
module hcbd_step #(
  parameter int LINE_CAP = 256
) (
  input  hcbd_pkg::in_item_t           item,
  input  hcbd_pkg::dec_state_t         st,
  input  logic [$clog2(LINE_CAP)-1:0]  line_count,
  input  hcbd_pkg::cfg_t               cfg,
  output hcbd_pkg::dec_state_t         st_next,
  output logic [$clog2(LINE_CAP)-1:0]  line_count_next,
  output hcbd_pkg::out_item_t          res
);

  localparam int LCW = $clog2(LINE_CAP);
  localparam logic [LCW-1:0] LineMax = LCW'(LINE_CAP - 1);

  hcbd_pkg::dec_state_t s;
  logic [LCW-1:0] lc;
  logic [7:0]     b;
  logic [4:0]     hx;
  logic [2:0]     status;
  logic           valid;
  logic           cend;
  logic           cons;
  logic [63:0]    rem_dec;

  assign b       = item.byte_in;
  assign hx      = hcbd_pkg::hex_val(b);

  // state update for one byte
  always_comb begin
    s      = st;
    lc     = line_count;
    status = hcbd_pkg::ST_MORE;
    valid  = 1'b0;
    cend   = 1'b0;
    cons   = 1'b1;
    if (item.restart) begin
      s       = '0;
      s.phase = hcbd_pkg::PH_SIZE;
      lc      = '0;
    end
    rem_dec = s.size_rem - 64'd1;
    case (s.phase)
      hcbd_pkg::PH_DONE: begin
        status = hcbd_pkg::ST_COMPLETE;
        cons   = 1'b0;
      end
      hcbd_pkg::PH_SIZE: begin
        if (s.cr_pending) begin
          if ((b != hcbd_pkg::CH_LF) || s.line_invalid || !s.has_digit) begin
            s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b0; status = hcbd_pkg::ST_BAD;
          end else begin
            s.phase        = (s.size_rem == 64'd0) ? hcbd_pkg::PH_TRAIL : hcbd_pkg::PH_DATA;
            s.cr_pending   = 1'b0;
            s.has_digit    = 1'b0;
            s.in_ext       = 1'b0;
            s.line_invalid = 1'b0;
            s.colon_seen   = 1'b0;
            lc             = '0;
          end
        end else if (b == hcbd_pkg::CH_CR) begin
          s.cr_pending = 1'b1;
        end else if (b == hcbd_pkg::CH_LF) begin
          s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b0; status = hcbd_pkg::ST_BAD;
        end else if (lc >= LineMax) begin
          s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b1; status = hcbd_pkg::ST_LARGE;
        end else begin
          lc = lc + LCW'(1);
          // size digits, then extension text
          if (!s.line_invalid) begin
            if (s.in_ext) begin
              if ((b == hcbd_pkg::CH_DEL) || ((b < hcbd_pkg::CH_SP) && (b != hcbd_pkg::CH_TAB))) begin
                s.line_invalid = 1'b1;
              end
            end else if (b == hcbd_pkg::CH_SEMI) begin
              s.in_ext = 1'b1;
            end else if (!hx[4] || (s.size_rem[63:60] != 4'd0)) begin
              s.line_invalid = 1'b1;
            end else begin
              s.size_rem  = {s.size_rem[59:0], hx[3:0]};
              s.has_digit = 1'b1;
            end
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        if (s.payload_total >= cfg.max_body_bytes) begin
          s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b1; status = hcbd_pkg::ST_LARGE;
        end else begin
          valid           = 1'b1;
          status          = hcbd_pkg::ST_DATA;
          s.payload_total = s.payload_total + 48'd1;
          s.size_rem      = rem_dec;
          if (rem_dec == 64'd0) begin
            cend    = 1'b1;
            s.phase = hcbd_pkg::PH_CRLF;
          end
        end
      end
      hcbd_pkg::PH_CRLF: begin
        if (!s.cr_pending) begin
          if (b == hcbd_pkg::CH_CR) begin
            s.cr_pending = 1'b1;
          end else begin
            s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b0; status = hcbd_pkg::ST_BAD;
          end
        end else if (b == hcbd_pkg::CH_LF) begin
          s.phase        = hcbd_pkg::PH_SIZE;
          s.cr_pending   = 1'b0;
          s.has_digit    = 1'b0;
          s.in_ext       = 1'b0;
          s.line_invalid = 1'b0;
          s.colon_seen   = 1'b0;
          s.size_rem     = 64'd0;
          lc             = '0;
        end else begin
          s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b0; status = hcbd_pkg::ST_BAD;
        end
      end
      hcbd_pkg::PH_TRAIL: begin
        if (s.cr_pending) begin
          // lf after cr is counted without a limit check
          if (s.trl_bytes != 16'hffff) begin
            s.trl_bytes = s.trl_bytes + 16'd1;
          end
          if (b != hcbd_pkg::CH_LF) begin
            s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b0; status = hcbd_pkg::ST_BAD;
          end else if (lc == '0) begin
            s.phase      = hcbd_pkg::PH_DONE;
            s.cr_pending = 1'b0;
            status       = hcbd_pkg::ST_COMPLETE;
          end else if ((s.trl_fields >= cfg.max_trailer_fields) || s.line_invalid ||
                       !s.colon_seen) begin
            s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b0; status = hcbd_pkg::ST_BAD;
          end else begin
            s.trl_fields   = s.trl_fields + 8'd1;
            s.cr_pending   = 1'b0;
            s.has_digit    = 1'b0;
            s.in_ext       = 1'b0;
            s.line_invalid = 1'b0;
            s.colon_seen   = 1'b0;
            lc             = '0;
          end
        end else if (s.trl_bytes >= cfg.max_trailer_bytes) begin
          s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b1; status = hcbd_pkg::ST_LARGE;
        end else begin
          s.trl_bytes = s.trl_bytes + 16'd1;
          if (b == hcbd_pkg::CH_CR) begin
            s.cr_pending = 1'b1;
          end else if (b == hcbd_pkg::CH_LF) begin
            s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b0; status = hcbd_pkg::ST_BAD;
          end else if (lc >= LineMax) begin
            s.phase = hcbd_pkg::PH_FAIL; s.error_kind = 1'b1; status = hcbd_pkg::ST_LARGE;
          end else begin
            // field name up to the colon, then value text
            if (!s.line_invalid) begin
              if (!s.colon_seen) begin
                if (b == hcbd_pkg::CH_COLON) begin
                  if (lc == '0) begin
                    s.line_invalid = 1'b1;
                  end
                  s.colon_seen = 1'b1;
                end else if (!hcbd_pkg::is_token(b)) begin
                  s.line_invalid = 1'b1;
                end
              end else if ((b == hcbd_pkg::CH_DEL) || ((b < hcbd_pkg::CH_SP) &&
                           (b != hcbd_pkg::CH_SP) && (b != hcbd_pkg::CH_TAB))) begin
                s.line_invalid = 1'b1;
              end
            end
            lc = lc + LCW'(1);
          end
        end
      end
      default: begin
        // failed, sticky until restart
        s.phase = hcbd_pkg::PH_FAIL;
        status  = s.error_kind ? hcbd_pkg::ST_LARGE : hcbd_pkg::ST_BAD;
        cons    = 1'b0;
      end
    endcase
    if ((status == hcbd_pkg::ST_BAD) || (status == hcbd_pkg::ST_LARGE)) begin
      cons = 1'b0;
    end
  end

  // result assembly
  assign st_next             = s;
  assign line_count_next     = lc;
  assign res.body_byte       = valid ? b : 8'd0;
  assign res.body_valid      = valid;
  assign res.chunk_end       = cend;
  assign res.consumed        = cons;
  assign res.status          = status;
  assign res.phase           = s.phase;
  assign res.body_count      = s.payload_total;

endmodule

### design/http_chunked_body_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit: HTTP/1.1 chunked body decoder
// Decodes a chunked body one byte per transaction: size lines, payload,
// chunk CRLF and trailer fields, with body, trailer and line limits.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  item     | item_valid / item_stall    | item   (byte_in, restart)
//  result   | result_valid / result_stall| result (body byte, flags, status..)
//  config   | cfg_wr_en                  | cfg_index, cfg_data
//
//  one byte per cycle sustained while the result is not stalled; each byte
//  is held in the input register, then its result in the result register
//  the step logic reads and updates the decoder state in the same cycle
//  synchronous reset clears the decoder state, the valid flags and sets the
//  limit registers to their defaults; no clearing pass is needed
//  a stalled result holds the step; one more byte waits in the input register
//
module http_chunked_body_decoder_unit #(
  parameter int LINE_CAP = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  hcbd_pkg::in_item_t    item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output hcbd_pkg::out_item_t   result,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [47:0]           cfg_data
);

  localparam int LCW = $clog2(LINE_CAP);

  hcbd_pkg::in_item_t   item_reg;
  logic                 item_reg_valid;
  hcbd_pkg::cfg_t       cfg;
  hcbd_pkg::dec_state_t st;
  hcbd_pkg::dec_state_t st_next;
  logic [LCW-1:0]       line_count;
  logic [LCW-1:0]       line_count_next;
  hcbd_pkg::out_item_t  res_next;
  logic                 advance;
  logic                 step_fire;

  // flow control
  assign advance    = !result_valid || !result_stall;
  assign step_fire  = item_reg_valid && advance;
  assign item_stall = item_reg_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_reg_valid <= 1'b1;
    end else if (step_fire) begin
      item_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_reg <= item;
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_body_bytes     <= hcbd_pkg::MAX_BODY_RST;
      cfg.max_trailer_bytes  <= hcbd_pkg::MAX_TRL_B_RST;
      cfg.max_trailer_fields <= hcbd_pkg::MAX_TRL_F_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hcbd_pkg::REG_MAX_BODY:  cfg.max_body_bytes     <= cfg_data;
        hcbd_pkg::REG_MAX_TRL_B: cfg.max_trailer_bytes  <= cfg_data[15:0];
        hcbd_pkg::REG_MAX_TRL_F: cfg.max_trailer_fields <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // decode step
  hcbd_step #(
    .LINE_CAP (LINE_CAP)
  ) u_step (
    .item            (item_reg),
    .st              (st),
    .line_count      (line_count),
    .cfg             (cfg),
    .st_next         (st_next),
    .line_count_next (line_count_next),
    .res             (res_next)
  );

  // decoder state, all zero is the size line phase
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '0;
      line_count <= '0;
    end else if (step_fire) begin
      st         <= st_next;
      line_count <= line_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      result <= res_next;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> item_reg_valid && result_valid)
    else $error("input stalled without a pending transaction");

  a_body_is_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.body_valid |-> result.consumed && result.status == hcbd_pkg::ST_DATA)
    else $error("payload byte without data status");

  a_chunk_end_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.chunk_end |-> result.body_valid && result.phase == hcbd_pkg::PH_CRLF)
    else $error("chunk end outside of data crlf phase");

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    step_fire && (res_next.status == hcbd_pkg::ST_BAD || res_next.status == hcbd_pkg::ST_LARGE)
    |=> st.phase == hcbd_pkg::PH_FAIL)
    else $error("error status without failed phase");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of http_chunked_body_decoder_unit
// Feeds chunked message bodies one byte per transaction, from short directed
// cases for each parse error and limit through random well-formed, damaged
// and noise traffic under several limit settings. A behavioral decoder
// predicts every result, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

  localparam int LINE_CAP = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTED = 40;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam string FIELD_EXTRA = "!#$%&'*+-.^_`|~";
  localparam string FIELD_CHARS =
    "!#$%&'*+-.^_`|~0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  typedef enum int {FLIP_BYTE, DROP_BYTE, ADD_BYTE, ADD_SPECIAL} damage_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  hcbd_pkg::in_item_t  item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  hcbd_pkg::out_item_t result;
  logic                cfg_wr_en = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [47:0]         cfg_data = '0;

  http_chunked_body_decoder_unit #(.LINE_CAP(LINE_CAP)) uut (.*);

  // clock and run limit
  initial begin
    forever #10 clk = ~clk;
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // decoder model: limits and parse state
  logic [47:0] lim_body = hcbd_pkg::MAX_BODY_RST;
  logic [15:0] lim_trl_bytes = hcbd_pkg::MAX_TRL_B_RST;
  logic [7:0]  lim_trl_fields = hcbd_pkg::MAX_TRL_F_RST;
  logic [2:0]  dec_phase;
  logic        dec_too_large;
  logic        dec_cr;
  logic [63:0] dec_count;     // chunk size while parsing, bytes left in data
  logic        dec_digit;
  logic        dec_ext;
  logic        dec_bad_line;
  logic        dec_colon;
  int          dec_line_len;
  logic [47:0] dec_total;
  logic [15:0] dec_trl_bytes;
  logic [7:0]  dec_trl_fields;

  hcbd_pkg::out_item_t expected_results[$];
  int          mismatch_count = 0;
  int          sent_items = 0;
  logic [7:0]  msg[$];

  // stall control of the result side
  logic idle_on = 1'b0;
  logic hold_on = 1'b0;
  int   stall_left = 0;

  task automatic clear_line();
    dec_cr = 1'b0;
    dec_digit = 1'b0;
    dec_ext = 1'b0;
    dec_bad_line = 1'b0;
    dec_line_len = 0;
    dec_colon = 1'b0;
  endtask

  task automatic clear_decoder();
    dec_phase = hcbd_pkg::PH_SIZE;
    dec_too_large = 1'b0;
    dec_count = '0;
    dec_total = '0;
    dec_trl_bytes = '0;
    dec_trl_fields = '0;
    clear_line();
  endtask

  function automatic logic [2:0] enter_fail(input logic [2:0] st);
    dec_phase = hcbd_pkg::PH_FAIL;
    dec_too_large = (st == hcbd_pkg::ST_LARGE);
    return st;
  endfunction

  function automatic int digit_value(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    return -1;
  endfunction

  function automatic logic is_field_char(input logic [7:0] b);
    if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
        (b >= 8'h61 && b <= 8'h7a)) return 1'b1;
    for (int i = 0; i < FIELD_EXTRA.len(); i++)
      if (FIELD_EXTRA[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  // one byte of a chunk size line, errors held until the LF
  task automatic size_line_char(input logic [7:0] b);
    int d;
    if (dec_bad_line) return;
    if (dec_ext) begin
      if (b == hcbd_pkg::CH_DEL || (b < hcbd_pkg::CH_SP && b != hcbd_pkg::CH_TAB))
        dec_bad_line = 1'b1;
      return;
    end
    if (b == hcbd_pkg::CH_SEMI) begin
      dec_ext = 1'b1;
      return;
    end
    d = digit_value(b);
    if (d < 0 || dec_count > ((64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) >> 4)) begin
      dec_bad_line = 1'b1;
      return;
    end
    dec_count = (dec_count << 4) + 64'(d);
    dec_digit = 1'b1;
  endtask

  // one byte of a trailer field line
  task automatic field_line_char(input logic [7:0] b);
    if (dec_bad_line) return;
    if (!dec_colon) begin
      if (b == hcbd_pkg::CH_COLON) begin
        if (dec_line_len == 0) dec_bad_line = 1'b1;
        dec_colon = 1'b1;
      end else if (!is_field_char(b)) begin
        dec_bad_line = 1'b1;
      end
    end else if (b == hcbd_pkg::CH_DEL || (b < hcbd_pkg::CH_SP && b != hcbd_pkg::CH_TAB)) begin
      dec_bad_line = 1'b1;
    end
  endtask

  // expected result of one input transaction
  task automatic decode_step(input hcbd_pkg::in_item_t it, output hcbd_pkg::out_item_t r);
    logic [7:0] b;
    logic [2:0] st;
    b = it.byte_in;
    st = hcbd_pkg::ST_MORE;
    r = '0;
    r.consumed = 1'b1;
    if (it.restart) clear_decoder();
    if (dec_phase == hcbd_pkg::PH_DONE) begin
      st = hcbd_pkg::ST_COMPLETE;
      r.consumed = 1'b0;
    end else if (dec_phase >= hcbd_pkg::PH_FAIL) begin
      dec_phase = hcbd_pkg::PH_FAIL;
      st = dec_too_large ? hcbd_pkg::ST_LARGE : hcbd_pkg::ST_BAD;
    end else if (dec_phase == hcbd_pkg::PH_SIZE) begin
      if (dec_cr) begin
        if (b != hcbd_pkg::CH_LF || dec_bad_line || !dec_digit) begin
          st = enter_fail(hcbd_pkg::ST_BAD);
        end else begin
          dec_phase = (dec_count == 0) ? hcbd_pkg::PH_TRAIL : hcbd_pkg::PH_DATA;
          clear_line();
        end
      end else if (b == hcbd_pkg::CH_CR) begin
        dec_cr = 1'b1;
      end else if (b == hcbd_pkg::CH_LF) begin
        st = enter_fail(hcbd_pkg::ST_BAD);
      end else if (dec_line_len >= LINE_CAP - 1) begin
        st = enter_fail(hcbd_pkg::ST_LARGE);
      end else begin
        dec_line_len++;
        size_line_char(b);
      end
    end else if (dec_phase == hcbd_pkg::PH_DATA) begin
      if (dec_total >= lim_body) begin
        st = enter_fail(hcbd_pkg::ST_LARGE);
      end else begin
        r.body_byte = b;
        r.body_valid = 1'b1;
        dec_total++;
        dec_count--;
        st = hcbd_pkg::ST_DATA;
        if (dec_count == 0) begin
          r.chunk_end = 1'b1;
          dec_phase = hcbd_pkg::PH_CRLF;
        end
      end
    end else if (dec_phase == hcbd_pkg::PH_CRLF) begin
      if (!dec_cr) begin
        if (b == hcbd_pkg::CH_CR) dec_cr = 1'b1;
        else st = enter_fail(hcbd_pkg::ST_BAD);
      end else if (b == hcbd_pkg::CH_LF) begin
        dec_phase = hcbd_pkg::PH_SIZE;
        clear_line();
        dec_count = '0;
      end else begin
        st = enter_fail(hcbd_pkg::ST_BAD);
      end
    end else begin
      // trailer section
      if (dec_cr) begin
        if (dec_trl_bytes != 16'hFFFF) dec_trl_bytes++;
        if (b != hcbd_pkg::CH_LF) begin
          st = enter_fail(hcbd_pkg::ST_BAD);
        end else if (dec_line_len == 0) begin
          dec_phase = hcbd_pkg::PH_DONE;
          dec_cr = 1'b0;
          st = hcbd_pkg::ST_COMPLETE;
        end else if (dec_trl_fields >= lim_trl_fields || dec_bad_line || !dec_colon) begin
          st = enter_fail(hcbd_pkg::ST_BAD);
        end else begin
          dec_trl_fields++;
          clear_line();
        end
      end else if (dec_trl_bytes >= lim_trl_bytes) begin
        st = enter_fail(hcbd_pkg::ST_LARGE);
      end else begin
        dec_trl_bytes++;
        if (b == hcbd_pkg::CH_CR) begin
          dec_cr = 1'b1;
        end else if (b == hcbd_pkg::CH_LF) begin
          st = enter_fail(hcbd_pkg::ST_BAD);
        end else if (dec_line_len >= LINE_CAP - 1) begin
          st = enter_fail(hcbd_pkg::ST_LARGE);
        end else begin
          field_line_char(b);
          dec_line_len++;
        end
      end
    end
    if (st == hcbd_pkg::ST_BAD || st == hcbd_pkg::ST_LARGE) r.consumed = 1'b0;
    r.status = st;
    r.phase = dec_phase;
    r.body_count = dec_total;
  endtask

  task automatic log_mismatch(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want,
               cycle_count);
  endtask

  // predict on each input transaction, check each result transaction
  always @(posedge clk) begin : watch
    hcbd_pkg::out_item_t want;
    if (!rst && item_valid && !item_stall) begin
      decode_step(item, want);
      expected_results.push_back(want);
    end
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        log_mismatch("result with none expected", 64'(result.status), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (result.body_byte !== want.body_byte)
          log_mismatch("body_byte", 64'(result.body_byte), 64'(want.body_byte));
        if (result.body_valid !== want.body_valid)
          log_mismatch("body_valid", 64'(result.body_valid), 64'(want.body_valid));
        if (result.chunk_end !== want.chunk_end)
          log_mismatch("chunk_end", 64'(result.chunk_end), 64'(want.chunk_end));
        if (result.consumed !== want.consumed)
          log_mismatch("consumed", 64'(result.consumed), 64'(want.consumed));
        if (result.status !== want.status)
          log_mismatch("status", 64'(result.status), 64'(want.status));
        if (result.phase !== want.phase)
          log_mismatch("phase", 64'(result.phase), 64'(want.phase));
        if (result.body_count !== want.body_count)
          log_mismatch("body_count", 64'(result.body_count), 64'(want.body_count));
      end
    end
  end

  // result stall: random bursts plus the long hold
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      result_stall <= 1'b1;
    end else begin
      result_stall <= hold_on;
    end
  end

  // send one byte, with an occasional random gap before it
  task automatic send_byte(input logic [7:0] b, input logic restart);
    hcbd_pkg::in_item_t it;
    int gap;
    it.byte_in = b;
    it.restart = restart;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sent_items++;
  endtask

  // wait until every expected result is in and the pipe is empty
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [47:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      hcbd_pkg::REG_MAX_BODY:  lim_body = val;
      hcbd_pkg::REG_MAX_TRL_B: lim_trl_bytes = val[15:0];
      hcbd_pkg::REG_MAX_TRL_F: lim_trl_fields = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [47:0] body, input logic [15:0] trl_bytes,
                            input logic [7:0] trl_fields);
    write_limit(hcbd_pkg::REG_MAX_BODY, body);
    write_limit(hcbd_pkg::REG_MAX_TRL_B, 48'(trl_bytes));
    write_limit(hcbd_pkg::REG_MAX_TRL_F, 48'(trl_fields));
  endtask

  // message building
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic feed_message();
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == 0);
  endtask

  task automatic run_text(input string s);
    msg.delete();
    add_text(s);
    feed_message();
  endtask

  function automatic logic [7:0] ext_char();
    if ($urandom_range(0, 5) == 0) return hcbd_pkg::CH_TAB;
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] value_char();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return hcbd_pkg::CH_TAB;
    if (r == 1) return hcbd_pkg::CH_SP;
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic int chunk_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 8);
    if (r < 19) return $urandom_range(9, 40);
    return $urandom_range(41, 300);
  endfunction

  task automatic add_size_line(input longint unsigned n);
    string s;
    s = $sformatf("%0h", n);
    if ($urandom_range(0, 1)) s = s.toupper();
    if ($urandom_range(0, 7) == 0) s = {"0", s};
    add_text(s);
    if ($urandom_range(0, 5) == 0) begin
      msg.push_back(hcbd_pkg::CH_SEMI);
      repeat ($urandom_range(0, 6)) msg.push_back(ext_char());
    end
    add_text("\r\n");
  endtask

  // well-formed body with random chunks and trailer fields
  task automatic build_message();
    int n;
    msg.delete();
    repeat ($urandom_range(0, 3)) begin
      n = chunk_len();
      add_size_line(n);
      repeat (n) msg.push_back(8'($urandom_range(0, 255)));
      add_text("\r\n");
    end
    add_size_line(0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 6))
        msg.push_back(FIELD_CHARS[$urandom_range(0, FIELD_CHARS.len() - 1)]);
      msg.push_back(hcbd_pkg::CH_COLON);
      repeat ($urandom_range(0, 6)) msg.push_back(value_char());
      add_text("\r\n");
    end
    add_text("\r\n");
  endtask

  task automatic damage_message();
    int pos;
    damage_t kind;
    logic [7:0] junk;
    pos = $urandom_range(0, msg.size() - 1);
    kind = damage_t'($urandom_range(0, 3));
    case ($urandom_range(0, 6))
      0: junk = hcbd_pkg::CH_CR;
      1: junk = hcbd_pkg::CH_LF;
      2: junk = hcbd_pkg::CH_COLON;
      3: junk = hcbd_pkg::CH_SEMI;
      4: junk = hcbd_pkg::CH_DEL;
      5: junk = hcbd_pkg::CH_TAB;
      default: junk = 8'h00;
    endcase
    case (kind)
      FLIP_BYTE: msg[pos] = 8'($urandom_range(0, 255));
      DROP_BYTE: msg.delete(pos);
      ADD_BYTE: msg.insert(pos, 8'($urandom_range(0, 255)));
      default: msg.insert(pos, junk);
    endcase
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  // complete bodies, hex case, extensions, trailers, bytes after completion
  task automatic test_wellformed();
    msg.delete();
    add_text("4\r\nWiki\r\n5;ext=v");
    msg.push_back(hcbd_pkg::CH_TAB);
    add_text("1\r\npedia\r\nb\r\n");
    msg.push_back(8'h00);
    msg.push_back(8'hff);
    add_text("lo world!\r\nA\r\n0123456789\r\n0\r\nExpires: x\r\n\r\n");
    feed_message();
    send_byte("Z", 1'b0);
    // restart in the middle of a chunk
    run_text("5\r\nab");
    run_text("3\r\nxyz\r\n0\r\n\r\n");
  endtask

  task automatic test_size_line_errors();
    run_text("\n");                       // bare line feed
    run_text("5\rX");                     // carriage return without line feed
    run_text("5g\r\n");                   // non-hex digit
    run_text("10000000000000000\r\n");    // value past 64 bits
    run_text("FFFFFFFFFFFFFFFF\r\nab");   // largest value that fits
    run_text(";x\r\n");                   // no digit
    msg.delete();
    add_text("5;a");
    msg.push_back(8'h01);                 // control byte in extension
    add_text("\r\n");
    feed_message();
    msg.delete();
    add_text("5;a");
    msg.push_back(hcbd_pkg::CH_DEL);
    add_text("\r\n");
    feed_message();
    msg.delete();
    repeat (LINE_CAP) msg.push_back(8'h30);  // line one byte too long
    feed_message();
    send_byte("q", 1'b0);
  endtask

  task automatic test_chunk_crlf_errors();
    run_text("1\r\nxy");
    run_text("1\r\nx\rz");
    run_text("1\r\nx\n");
  endtask

  task automatic test_trailer_errors();
    run_text("0\r\n:v\r\n\r\n");          // empty field name
    run_text("0\r\nName v\r\n\r\n");      // no colon
    run_text("0\r\nName\r\n\r\n");
    run_text("0\r\nNa(me: v\r\n\r\n");    // bad name character
    msg.delete();
    add_text("0\r\nN: a");
    msg.push_back(8'h01);
    add_text("\r\n\r\n");
    feed_message();
    msg.delete();
    add_text("0\r\nN: a");
    msg.push_back(hcbd_pkg::CH_DEL);
    add_text("\r\n\r\n");
    feed_message();
    run_text("0\r\nN\n");
    run_text("0\r\nN: v\rx");
    msg.delete();
    add_text("0\r\n");
    repeat (LINE_CAP) msg.push_back(8'h61);
    feed_message();
  endtask

  task automatic test_limits();
    set_limits(48'd0, 16'd0, 8'd0);
    run_text("1\r\na");
    run_text("0\r\n\r\n");
    set_limits(48'd3, 16'd5, 8'd0);
    run_text("5\r\nabcde");
    run_text("0\r\nab:c\r\n\r\n");
    write_limit(hcbd_pkg::REG_MAX_TRL_B, 48'd100);
    run_text("0\r\nA:b\r\n\r\n");
    write_limit(hcbd_pkg::REG_MAX_TRL_F, 48'd1);
    run_text("0\r\nA:b\r\n\r\n");
    run_text("0\r\nA:b\r\nC:d\r\n\r\n");
    // unused index leaves every limit alone
    write_limit(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
    run_text("2\r\nabcd");
    set_limits(48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF);
    run_text("3\r\nabc\r\n0\r\nA:b\r\nC:d\r\n\r\n");
  endtask

  // random traffic under several limit settings
  task automatic test_random_traffic();
    int quota;
    int target;
    quota = RANDOM_ITEMS / 4;
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: set_limits(hcbd_pkg::MAX_BODY_RST, hcbd_pkg::MAX_TRL_B_RST,
                      hcbd_pkg::MAX_TRL_F_RST);
        1: set_limits(48'd24, 16'd20, 8'd1);
        2: set_limits(48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF);
        default: set_limits(48'($urandom_range(0, 60)), 16'($urandom_range(0, 40)),
                            8'($urandom_range(0, 3)));
      endcase
      target = sent_items + quota;
      while (sent_items < target) begin
        idle_on <= ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 9))
          6, 7: begin
            build_message();
            damage_message();
            feed_message();
          end
          8: send_noise();
          9: begin
            build_message();
            feed_message();
            send_noise();
          end
          default: begin
            build_message();
            feed_message();
          end
        endcase
      end
    end
  endtask

  // long result hold while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    drain();
    idle_on <= 1'b0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    msg.delete();
    add_text("20\r\n");
    repeat (32) msg.push_back(8'($urandom_range(0, 255)));
    add_text("\r\n0\r\n\r\n");
    feed_message();
    drain();
  endtask

  // back-to-back bodies with no idling
  task automatic test_steady_stream();
    idle_on <= 1'b0;
    repeat (2) begin
      build_message();
      feed_message();
    end
  endtask

  initial begin
    clear_decoder();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    idle_on <= 1'b1;
    test_wellformed();
    test_size_line_errors();
    test_chunk_crlf_errors();
    test_trailer_errors();
    test_limits();
    test_random_traffic();
    test_backpressure();
    test_steady_stream();
    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/hcbd_pkg.sv
design/hcbd_step.sv
design/http_chunked_body_decoder_unit.sv
tb/tb.sv
